// File: hw/rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the partition fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int SIZE_W    = 16;
  localparam int ENTRY_W   = 3;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd3;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // write one entry from the request
    logic start;   // set up a new scan
    logic read;    // read the entry at the scan position
    logic commit;  // mark the pick used and load the response register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer of the allocator: takes requests and steps the table scan.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl #(
  parameter int NUM_BLOCKS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic             req_type,
  output logic                  req_stall,
  input  wire pfa_pkg::status_t status,
  output pfa_pkg::cmd_t         cmd,
  output pfa_pkg::state_t       state
);

  localparam int CW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  pfa_pkg::state_t state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      pfa_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req_type == pfa_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            count_next = '0;
            state_next = pfa_pkg::ST_SCAN;
          end
        end
      end
      pfa_pkg::ST_SCAN: begin
        cmd.read = 1'b1;
        if (count == CW'(NUM_BLOCKS - 1)) begin
          state_next = pfa_pkg::ST_LAST;
        end else begin
          count_next = count + 1'b1;
        end
      end
      // last read is compared in this cycle
      pfa_pkg::ST_LAST: begin
        state_next = pfa_pkg::ST_DONE;
      end
      pfa_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfa_dpath.sv
// ----------------------------------------------------------------------------
// pfa_dpath
// Partition table, used flags, rover, fit compare and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_dpath #(
  parameter int NUM_BLOCKS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pfa_pkg::cmd_t                  cmd,
  output pfa_pkg::status_t                    status,
  input  wire logic [pfa_pkg::ENTRY_W-1:0]    entry_index,
  input  wire logic [pfa_pkg::SIZE_W-1:0]     size_value,
  input  wire logic                           cfg_valid,
  input  wire logic [pfa_pkg::MODE_W-1:0]     cfg_mode,
  input  wire logic                           rsp_stall,
  output logic                                rsp_valid,
  output logic                                granted,
  output logic [pfa_pkg::ENTRY_W-1:0]         block_index,
  output logic [pfa_pkg::SIZE_W-1:0]          grant_size
);

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int EW = pfa_pkg::ENTRY_W;

  logic [pfa_pkg::SIZE_W-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]      loaded;
  logic [NUM_BLOCKS-1:0]      used;
  logic [pfa_pkg::MODE_W-1:0] mode;
  logic [IW-1:0]              rover;
  logic [IW-1:0]              pos;
  logic [pfa_pkg::SIZE_W-1:0] req_size;

  logic                       rd_valid;
  logic [IW-1:0]              rd_idx;
  logic [pfa_pkg::SIZE_W-1:0] rd_data;
  logic                       rd_used;
  logic                       rd_loaded;

  logic                       found;
  logic [IW-1:0]              pick;
  logic [pfa_pkg::SIZE_W-1:0] best;

  logic [EW+3:0]              entry_ext;
  logic                       in_range;
  logic [IW+EW-1:0]           waddr_wide;
  logic [IW-1:0]              waddr;
  logic [IW+EW-1:0]           pick_wide;
  logic [pfa_pkg::SIZE_W-1:0] cand_size;
  logic                       cand_fit;
  logic                       take;

  assign entry_ext  = {4'b0000, entry_index};
  assign in_range   = entry_ext < (EW+4)'(NUM_BLOCKS);
  assign waddr_wide = {{IW{1'b0}}, entry_index};
  assign waddr      = waddr_wide[IW-1:0];
  assign pick_wide  = {{EW{1'b0}}, pick};

  // an entry never loaded reads as size zero
  assign cand_size = rd_loaded ? rd_data : '0;
  assign cand_fit  = rd_valid && !rd_used && (cand_size >= req_size);
  always_comb begin
    take = 1'b0;
    if (cand_fit) begin
      if (!found) begin
        take = 1'b1;
      end else if (mode == pfa_pkg::MODE_BEST) begin
        take = cand_size < best;
      end else if (mode == pfa_pkg::MODE_WORST) begin
        take = cand_size > best;
      end
    end
  end

  assign status.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      mem[waddr] <= size_value;
    end
    if (cmd.read) begin
      rd_data <= mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    rd_idx    <= pos;
    rd_used   <= used[pos];
    rd_loaded <= loaded[pos];
    if (cmd.start) begin
      req_size <= size_value;
    end
    if (take) begin
      pick <= rd_idx;
      best <= cand_size;
    end
    if (cmd.commit) begin
      granted     <= found;
      block_index <= found ? pick_wide[EW-1:0] : '0;
      grant_size  <= found ? best : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      used      <= '0;
      mode      <= pfa_pkg::MODE_FIRST;
      rover     <= '0;
      pos       <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.read;
      if (cfg_valid) begin
        mode <= cfg_mode;
      end
      if (cmd.load && in_range) begin
        loaded[waddr] <= 1'b1;
        used[waddr]   <= 1'b0;
      end
      if (cmd.start) begin
        found <= 1'b0;
        pos   <= (mode == pfa_pkg::MODE_NEXT) ? rover : '0;
      end else if (cmd.read) begin
        pos <= (pos == IW'(NUM_BLOCKS - 1)) ? '0 : pos + 1'b1;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
        if (found) begin
          used[pick] <= 1'b1;
          if (mode == pfa_pkg::MODE_NEXT) begin
            rover <= pick;
          end
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Fixed partition allocator with first, best, worst and next fit placement.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid / req_stall with req_type, entry_index and
// size_value. A load request writes one entry's size, frees the entry and
// gives no response; the next request can follow at once. An allocate
// request scans the table one entry per cycle through the registered read
// port of the size memory in its read states, compares the last entry in
// a compare state and loads the response register in a commit state; the
// block takes no new request until that commit.
// Responses leave on rsp_valid / rsp_stall with granted, block_index and
// grant_size. While a response is stalled the block still takes requests;
// a later allocate waits in its commit cycle until the register frees.
// fit_mode is written through cfg_valid / cfg_ready, always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset clears all used flags, the rover and fit_mode; every entry then
// reads as size zero until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_fit_allocator #(
  parameter int NUM_BLOCKS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire logic                           req_type,
  input  wire logic [pfa_pkg::ENTRY_W-1:0]    entry_index,
  input  wire logic [pfa_pkg::SIZE_W-1:0]     size_value,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output logic                                granted,
  output logic [pfa_pkg::ENTRY_W-1:0]         block_index,
  output logic [pfa_pkg::SIZE_W-1:0]          grant_size,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pfa_pkg::MODE_W-1:0]     fit_mode
);

  pfa_pkg::cmd_t    cmd;
  pfa_pkg::status_t status;
  pfa_pkg::state_t  state;

  assign cfg_ready = 1'b1;

  pfa_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_type (req_type),
    .req_stall(req_stall),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  pfa_dpath #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .entry_index(entry_index),
    .size_value (size_value),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_mode   (fit_mode),
    .rsp_stall  (rsp_stall),
    .rsp_valid  (rsp_valid),
    .granted    (granted),
    .block_index(block_index),
    .grant_size (grant_size)
  );

  // an allocate request holds off the next request
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req_type == pfa_pkg::REQ_ALLOC) |=> req_stall)
    else $error("request taken during allocate scan");

  // a load request leaves the block idle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req_type == pfa_pkg::REQ_LOAD) |=> !req_stall)
    else $error("load request left the block busy");

  // a commit always presents a response next cycle
  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit without response");

  // commits come only from the done state
  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (state == pfa_pkg::ST_DONE))
    else $error("commit outside the done state");

  // a refused allocate carries a zero index and size
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !granted) |-> (block_index == '0 && grant_size == '0))
    else $error("refused response carries nonzero fields");

endmodule

`default_nettype wire
